[hdl/record_sort_by_key_macros.svh]
// Assertion macros shared by the record sort RTL files.
`ifndef RECORD_SORT_BY_KEY_MACROS_SVH
`define RECORD_SORT_BY_KEY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSBK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSBK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rsbk_pkg.sv]
// Shared types for the record sort block.
`timescale 1ns / 1ps

package rsbk_pkg;

    // One stored record: sort key and the tag that travels with it.
    typedef struct packed {
        logic [15:0] key;
        logic [15:0] tag;
    } rec_t;

    // Controls from the sequencer to the compare and carry unit.
    typedef struct packed {
        logic load;
        logic step;
    } carry_ctl_t;

endpackage

[hdl/rsbk_store.sv]
// Record memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module rsbk_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  rsbk_pkg::rec_t    wdata,
    input  logic [ADDR_W-1:0] raddr,
    output rsbk_pkg::rec_t    rdata
);
    import rsbk_pkg::*;

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    // Write and registered read share one clocked block.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rsbk_carry_unit.sv]
// Shared compare unit holding the record carried along one bubble pass.
`timescale 1ns / 1ps

module rsbk_carry_unit (
    input  logic                 clk,
    input  rsbk_pkg::carry_ctl_t ctl,
    input  rsbk_pkg::rec_t       rd_rec,
    output rsbk_pkg::rec_t       carry_rec,
    output rsbk_pkg::rec_t       wr_rec
);
    import rsbk_pkg::*;

    rec_t carry_reg;
    rec_t carry_next;
    logic swap;

    // Swap only on a strictly greater key, so equal keys keep arrival order.
    always_comb
    begin
        swap       = (carry_reg.key > rd_rec.key);
        carry_next = carry_reg;
        wr_rec     = carry_reg;
        if (ctl.load)
        begin
            carry_next = rd_rec;
        end
        else if (ctl.step)
        begin
            if (swap)
            begin
                wr_rec = rd_rec;
            end
            else
            begin
                carry_next = rd_rec;
            end
        end
    end

    // The carried record is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign carry_rec = carry_reg;

endmodule

[hdl/record_sort_by_key.sv]
// Top level of the record sort block: sequencer, memory and compare unit.
//
//  Channel | Dir | Handshake                | Words
//  input   | in  | start high, busy low     | record_duration, record_tag, last_record
//  result  | out | result_valid, one cycle  | sorted_duration, sorted_tag, last_out, overflowed
//
// A record without the last mark is taken in the idle state; busy stays low.
// After the last record of n held records, the block runs n-1 bubble passes,
// each paced by the single read and write port of the record memory and the one
// comparator; the n sorted records are then read out in order.
// Reset clears the sequencer, the count and the overflow flag; memory is not cleared.
// Results cannot be stalled: each word is valid for exactly one cycle.
`timescale 1ns / 1ps
`include "record_sort_by_key_macros.svh"

module record_sort_by_key #(
    parameter int MAX_RECORDS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] record_duration,
    input  logic [15:0] record_tag,
    input  logic        last_record,
    output logic        result_valid,
    output logic [15:0] sorted_duration,
    output logic [15:0] sorted_tag,
    output logic        last_out,
    output logic        overflowed
);
    import rsbk_pkg::*;

    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRIME = 6'b000010,
        S_LOAD  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] optr_reg, optr_next;
    logic              pend_reg, pend_next;
    logic              olast_reg, olast_next;
    logic              oovf_reg, oovf_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    rec_t              mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    rec_t              mem_rdata;
    rec_t              in_rec;
    rec_t              carry_rec;
    rec_t              unit_wr_rec;
    carry_ctl_t        ctl;

    assign in_rec.key = record_duration;
    assign in_rec.tag = record_tag;

    rsbk_store #(
        .DEPTH  (MAX_RECORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rsbk_carry_unit u_carry (
        .clk       (clk),
        .ctl       (ctl),
        .rd_rec    (mem_rdata),
        .carry_rec (carry_rec),
        .wr_rec    (unit_wr_rec)
    );

    // Sequencer: store records, run the bubble passes, then read out in order.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        optr_next  = optr_reg;
        pend_next  = 1'b0;
        olast_next = 1'b0;
        oovf_next  = ovf_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[ADDR_W-1:0];
        mem_wdata  = in_rec;
        mem_raddr  = optr_reg;
        ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_record)
                    begin
                        pos_next  = '0;
                        optr_next = '0;
                        if (count_next >= CNT_W'(2))
                        begin
                            end_next   = ADDR_W'(count_next - CNT_W'(1));
                            state_next = S_PRIME;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_PRIME:
            begin
                mem_raddr  = '0;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                mem_raddr  = ADDR_W'(1);
                ctl.load   = 1'b1;
                pos_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                mem_raddr = pos_reg + ADDR_W'(2);
                ctl.step  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = unit_wr_rec;
                if (pos_reg == end_reg - ADDR_W'(1))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    pos_next = pos_reg + ADDR_W'(1);
                end
            end
            S_FLUSH:
            begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = carry_rec;
                end_next  = end_reg - ADDR_W'(1);
                if (end_reg == ADDR_W'(1))
                begin
                    optr_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PRIME;
                end
            end
            S_OUT:
            begin
                mem_raddr  = optr_reg;
                pend_next  = 1'b1;
                olast_next = (CNT_W'(optr_reg) == count_reg - CNT_W'(1));
                if (olast_next)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    optr_next = optr_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and status registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            end_reg   <= '0;
            optr_reg  <= '0;
            pend_reg  <= 1'b0;
            olast_reg <= 1'b0;
            oovf_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            end_reg   <= end_next;
            optr_reg  <= optr_next;
            pend_reg  <= pend_next;
            olast_reg <= olast_next;
            oovf_reg  <= oovf_next;
        end
    end

    // The result word comes straight from the registered memory read.
    assign busy            = (state_reg != S_IDLE);
    assign result_valid    = pend_reg;
    assign sorted_duration = mem_rdata.key;
    assign sorted_tag      = mem_rdata.tag;
    assign last_out        = olast_reg;
    assign overflowed      = oovf_reg;

    // Checks on the sequencer.
    `RSBK_ASSERT_NEXT(a_out_strobes, state_reg == S_OUT, result_valid,
        "a read-out cycle was not followed by a result strobe")
    `RSBK_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= MAX_CNT,
        "held record count exceeds the store capacity")
    `RSBK_ASSERT_SAME(a_scan_range, state_reg == S_SCAN, pos_reg < end_reg,
        "compare position ran past the end of the pass")
    `RSBK_ASSERT_SAME(a_last_clears, result_valid && last_out,
        state_reg == S_IDLE && count_reg == '0 && !ovf_reg,
        "batch state not cleared on the final result word")

endmodule

[sim/record_sort_by_key_tb.sv]
// Self-checking testbench for the record sort block, with a local sort predictor and random timing.
`timescale 1ns / 1ps

module record_sort_by_key_tb;
    import rsbk_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RECORD_GOAL  = 300;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    // One input word and one sorted output word as the testbench sees them.
    typedef struct {
        rec_t rec;
        logic last;
    } in_word_t;

    typedef struct {
        rec_t rec;
        logic last;
        logic ovf;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] record_duration = '0;
    logic [15:0] record_tag = '0;
    logic        last_record = 1'b0;
    logic        result_valid;
    logic [15:0] sorted_duration;
    logic [15:0] sorted_tag;
    logic        last_out;
    logic        overflowed;

    // Records waiting to be driven, and sorted words still to come back.
    in_word_t  record_feed[$];
    out_word_t expected_sorted[$];

    // Predictor copy of the batch store.
    rec_t held_recs[CAPACITY];
    int   held_n = 0;
    logic held_ovf = 1'b0;

    int fail_count = 0;
    int queued_words = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_cycles = 0;

    record_sort_by_key #(
        .MAX_RECORDS(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .record_duration(record_duration),
        .record_tag(record_tag),
        .last_record(last_record),
        .result_valid(result_valid),
        .sorted_duration(sorted_duration),
        .sorted_tag(sorted_tag),
        .last_out(last_out),
        .overflowed(overflowed)
    );

    always #5 clk = ~clk;

    // Store an accepted word; on the last one sort the batch stably and queue its output.
    task automatic file_record(input in_word_t w);
        rec_t      swap;
        out_word_t o;
        if (held_n < CAPACITY)
        begin
            held_recs[held_n] = w.rec;
            held_n++;
        end
        else
        begin
            held_ovf = 1'b1;
        end
        if (w.last)
        begin
            // Swapping only on a strictly greater key keeps equal keys in arrival order.
            for (int sweep = 0; sweep < held_n - 1; sweep++)
            begin
                for (int pos = 0; pos < held_n - 1 - sweep; pos++)
                begin
                    if (held_recs[pos].key > held_recs[pos + 1].key)
                    begin
                        swap = held_recs[pos];
                        held_recs[pos] = held_recs[pos + 1];
                        held_recs[pos + 1] = swap;
                    end
                end
            end
            for (int k = 0; k < held_n; k++)
            begin
                o.rec = held_recs[k];
                o.last = (k == held_n - 1);
                o.ovf = held_ovf;
                expected_sorted.push_back(o);
            end
            held_n = 0;
            held_ovf = 1'b0;
        end
    endtask

    // Keys lean towards ties and the ends of the range.
    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 7));
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(65528, 65535));
        endcase
    endfunction

    // Gap after an accepted word: mostly none or short, a few long, with bursts of none.
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst_left = $urandom_range(15, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic add_word(input logic [15:0] k, input logic [15:0] t, input logic l);
        in_word_t w;
        w.rec.key = k;
        w.rec.tag = t;
        w.last = l;
        record_feed.push_back(w);
        queued_words++;
    endtask

    task automatic add_batch(input int n);
        for (int i = 0; i < n; i++)
            add_word(pick_key(), 16'($urandom), i == n - 1);
    endtask

    // Stimulus, reset and the end of the run.
    initial
    begin
        int batch_idx;
        int n;

        // Single-record batches at both ends of key and tag.
        add_word(16'hFFFF, 16'h0000, 1'b1);
        add_word(16'h0000, 16'hFFFF, 1'b1);
        // Strictly descending keys, so every compare swaps.
        add_word(16'hFFFF, 16'h0001, 1'b0);
        add_word(16'h8000, 16'h0002, 1'b0);
        add_word(16'h7FFF, 16'h0003, 1'b0);
        add_word(16'h0001, 16'h0004, 1'b0);
        add_word(16'h0000, 16'h0005, 1'b1);
        // Repeated keys must keep their arrival order.
        add_word(16'h0005, 16'hAAAA, 1'b0);
        add_word(16'h0003, 16'h5555, 1'b0);
        add_word(16'h0005, 16'h0F0F, 1'b0);
        add_word(16'h0003, 16'hF0F0, 1'b0);
        add_word(16'h0005, 16'h1234, 1'b1);
        add_word(16'hFFFF, 16'h0001, 1'b0);
        add_word(16'hFFFF, 16'h0002, 1'b1);
        // Already in order, so nothing moves.
        add_word(16'h0000, 16'h0010, 1'b0);
        add_word(16'h0000, 16'h0011, 1'b0);
        add_word(16'h0001, 16'h0012, 1'b0);
        add_word(16'hFFFF, 16'h0013, 1'b1);

        // Random batches: mostly small, one exactly full, one where only the last word
        // is dropped, and one that drops several words.
        batch_idx = 0;
        while (queued_words < RECORD_GOAL)
        begin
            if (batch_idx == 2)
                n = CAPACITY;
            else if (batch_idx == 5)
                n = CAPACITY + 1;
            else if (batch_idx == 9)
                n = CAPACITY + 2 + $urandom_range(0, 4);
            else
                n = $urandom_range(1, 12);
            add_batch(n);
            batch_idx++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (record_feed.size() != 0 || expected_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Driver: offers the head of the feed and holds it until the block takes the word.
    always @(posedge clk or negedge rst_n)
    begin : feed_driver
        logic took;
        if (!rst_n)
        begin
            start <= 1'b0;
            record_duration <= '0;
            record_tag <= '0;
            last_record <= 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                file_record(record_feed.pop_front());
                gap_left = next_gap();
            end
            if (!start || took)
            begin
                if (gap_left == 0 && record_feed.size() != 0)
                begin
                    start <= 1'b1;
                    record_duration <= record_feed[0].rec.key;
                    record_tag <= record_feed[0].rec.tag;
                    last_record <= record_feed[0].last;
                end
                else
                begin
                    if (gap_left > 0)
                        gap_left--;
                    // Idle cycles carry junk on the data lines.
                    start <= 1'b0;
                    record_duration <= 16'($urandom);
                    record_tag <= 16'($urandom);
                    last_record <= 1'($urandom);
                end
            end
        end
    end

    // Monitor: every result word is compared with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && result_valid)
        begin
            if (expected_sorted.size() == 0)
            begin
                $error("unexpected result word: sorted_duration %0d, sorted_tag %0d",
                       sorted_duration, sorted_tag);
                fail_count++;
            end
            else
            begin
                want = expected_sorted.pop_front();
                if (sorted_duration !== want.rec.key)
                begin
                    $error("sorted_duration: expected %0d, got %0d", want.rec.key,
                           sorted_duration);
                    fail_count++;
                end
                if (sorted_tag !== want.rec.tag)
                begin
                    $error("sorted_tag: expected %0d, got %0d", want.rec.tag, sorted_tag);
                    fail_count++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out: expected %0b, got %0b", want.last, last_out);
                    fail_count++;
                end
                if (overflowed !== want.ovf)
                begin
                    $error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves either way for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
